/* src/bde_pkg.sv */
// Shared types and constants for the button debounce / event detector.
// No dependencies; every other file imports this package.
`default_nettype none

package bde_pkg;

    // fixed field widths of the channels and the register file
    localparam int CFG_W      = 16;
    localparam int TIME_IN_W  = 32;
    localparam int CNT_OUT_W  = 16;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam int DEF_COUNT_WIDTH = 16;
    localparam int DEF_TIME_WIDTH  = 32;

    // register defaults
    localparam logic             RST_ACTIVE_LEVEL = 1'b0;
    localparam logic [CFG_W-1:0] RST_DEBOUNCE     = 16'd30;
    localparam logic [CFG_W-1:0] RST_DC_WINDOW    = 16'd400;
    localparam logic [CFG_W-1:0] RST_HOLD_DELAY   = 16'd1500;
    localparam logic [CFG_W-1:0] RST_MODULUS      = 16'd1;

    typedef enum logic [2:0] {
        REG_ACTIVE_LEVEL   = 3'd0,
        REG_DEBOUNCE_DELAY = 3'd1,
        REG_DC_WINDOW      = 3'd2,
        REG_HOLD_DELAY     = 3'd3,
        REG_COUNT_MODULUS  = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_SETTLE,
        ST_MOD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             active_level;
        logic [CFG_W-1:0] debounce_delay;
        logic [CFG_W-1:0] dc_window;
        logic [CFG_W-1:0] hold_delay;
        logic [CFG_W-1:0] count_modulus;
    } t_cfg;

    // control of a serial unit: load operands, then advance one bit
    typedef struct packed {
        logic load;
        logic step;
    } t_unit_ctl;

endpackage

`default_nettype wire

/* src/bde_if.sv */
// Channel interfaces: raw sample transactions in, event result transactions out.
// Depends on bde_pkg for field widths.
`default_nettype none

interface bde_in_if import bde_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 pin_level;
    logic [TIME_IN_W-1:0] now_ms;
    logic                 clear_presses;
    logic                 clear_releases;

    modport source (output valid, pin_level, now_ms, clear_presses, clear_releases,
                    input ready);
    modport sink   (input valid, pin_level, now_ms, clear_presses, clear_releases,
                    output ready);
endinterface

interface bde_out_if import bde_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 is_pressed;
    logic                 just_pressed;
    logic                 just_released;
    logic                 changed;
    logic [CNT_OUT_W-1:0] press_count;
    logic [CNT_OUT_W-1:0] release_count;
    logic                 press_toggle;
    logic                 release_toggle;
    logic                 double_click;
    logic                 hold;
    logic                 nth_press;
    logic                 nth_release;

    modport source (output valid, is_pressed, just_pressed, just_released, changed,
                    press_count, release_count, press_toggle, release_toggle,
                    double_click, hold, nth_press, nth_release,
                    input ready);
    modport sink   (input valid, is_pressed, just_pressed, just_released, changed,
                    press_count, release_count, press_toggle, release_toggle,
                    double_click, hold, nth_press, nth_release,
                    output ready);
endinterface

`default_nettype wire

/* src/bde_cfg_regs.sv */
// APB register file holding the five configuration registers.
// Depends on bde_pkg (t_cfg, register indexes, reset values).
`default_nettype none

module bde_cfg_regs import bde_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_level   <= RST_ACTIVE_LEVEL;
            r_cfg.debounce_delay <= RST_DEBOUNCE;
            r_cfg.dc_window      <= RST_DC_WINDOW;
            r_cfg.hold_delay     <= RST_HOLD_DELAY;
            r_cfg.count_modulus  <= RST_MODULUS;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ACTIVE_LEVEL:   r_cfg.active_level   <= pwdata[0];
                REG_DEBOUNCE_DELAY: r_cfg.debounce_delay <= pwdata[CFG_W-1:0];
                REG_DC_WINDOW:      r_cfg.dc_window      <= pwdata[CFG_W-1:0];
                REG_HOLD_DELAY:     r_cfg.hold_delay     <= pwdata[CFG_W-1:0];
                REG_COUNT_MODULUS:  r_cfg.count_modulus  <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ACTIVE_LEVEL:   prdata = APB_DATA_W'(r_cfg.active_level);
            REG_DEBOUNCE_DELAY: prdata = APB_DATA_W'(r_cfg.debounce_delay);
            REG_DC_WINDOW:      prdata = APB_DATA_W'(r_cfg.dc_window);
            REG_HOLD_DELAY:     prdata = APB_DATA_W'(r_cfg.hold_delay);
            REG_COUNT_MODULUS:  prdata = APB_DATA_W'(r_cfg.count_modulus);
            default:            prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* src/bde_diff_cmp.sv */
// Bit-serial unit: computes (a - b) mod 2^TIME_WIDTH and tests it against k,
// LSB first, one bit per step. Depends on bde_pkg.
`default_nettype none

module bde_diff_cmp import bde_pkg::*; #(
    parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire t_unit_ctl             i_ctl,
    input  wire logic [TIME_WIDTH-1:0] i_a,
    input  wire logic [TIME_WIDTH-1:0] i_b,
    input  wire logic [CFG_W-1:0]      i_k,
    output logic                       o_gt
);

    logic [TIME_WIDTH-1:0] r_a;
    logic [TIME_WIDTH-1:0] r_b;
    logic [TIME_WIDTH-1:0] r_k;
    logic                  r_borrow;
    logic                  r_gt;
    logic                  dbit;
    logic                  borrow;

    // one full-subtractor bit
    assign dbit   = r_a[0] ^ r_b[0] ^ r_borrow;
    assign borrow = (~r_a[0] & r_b[0]) | (~r_a[0] & r_borrow) | (r_b[0] & r_borrow);
    assign o_gt   = r_gt;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a      <= i_a;
            r_b      <= i_b;
            r_k      <= TIME_WIDTH'(i_k);
            r_borrow <= 1'b0;
            r_gt     <= 1'b0;
        end else if (i_ctl.step) begin
            r_a      <= r_a >> 1;
            r_b      <= r_b >> 1;
            r_k      <= r_k >> 1;
            r_borrow <= borrow;
            // the highest differing bit seen last decides the order
            if (dbit != r_k[0]) begin
                r_gt <= dbit;
            end
        end
    end

endmodule

`default_nettype wire

/* src/bde_mod_test.sv */
// Restoring remainder unit: tests count mod modulus == 0, one dividend bit
// per step, MSB first. Modulus zero means 2^COUNT_WIDTH. Depends on bde_pkg.
`default_nettype none

module bde_mod_test import bde_pkg::*; #(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  wire logic                   i_clk,
    input  wire t_unit_ctl              i_ctl,
    input  wire logic [COUNT_WIDTH-1:0] i_count,
    input  wire logic [CFG_W-1:0]       i_modulus,
    output logic                        o_zero
);

    logic [COUNT_WIDTH-1:0] r_q;
    logic [CFG_W-1:0]       r_rem;
    logic [CFG_W-1:0]       r_mod;
    logic                   r_cnt_zero;
    logic [CFG_W:0]         trial;
    logic [CFG_W:0]         diff;

    assign trial  = {r_rem, r_q[COUNT_WIDTH-1]};
    assign diff   = trial - {1'b0, r_mod};
    assign o_zero = (r_mod == '0) ? r_cnt_zero : (r_rem == '0);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_q        <= i_count;
            r_rem      <= '0;
            r_mod      <= i_modulus;
            r_cnt_zero <= (i_count == '0);
        end else if (i_ctl.step) begin
            r_q <= r_q << 1;
            if (trial >= {1'b0, r_mod}) begin
                r_rem <= diff[CFG_W-1:0];
            end else begin
                r_rem <= trial[CFG_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

/* src/button_debounce_event_detector.sv */
// Debounced button event detector: one result transaction per sample transaction.
// Each accepted sample runs the bit-serial time subtract/compare pass, a settle step and
// the bit-serial remainder pass before its result is loaded into the output register.
// A new sample is taken only after that load; a stalled output delays it.
// Synchronous active-low reset restores register defaults and the power-up button state.
// Depends on bde_pkg, bde_if, bde_cfg_regs, bde_diff_cmp, bde_mod_test.
`default_nettype none

module button_debounce_event_detector import bde_pkg::*; #(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
    parameter int TIME_WIDTH  = DEF_TIME_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    bde_in_if.sink                     i_item,
    bde_out_if.source                  o_result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int STEPS_MAX = (TIME_WIDTH > COUNT_WIDTH) ? TIME_WIDTH : COUNT_WIDTH;
    localparam int SC_W      = $clog2(STEPS_MAX);

    t_cfg cfg;

    t_state r_state, n_state;
    logic [SC_W-1:0] r_cnt, n_cnt;

    // button state
    logic                   r_last_raw;
    logic                   r_settled;
    logic                   r_prev_stable;
    logic                   r_stable;
    logic [TIME_WIDTH-1:0]  r_settle_start;
    logic [COUNT_WIDTH-1:0] r_press_tally;
    logic [COUNT_WIDTH-1:0] r_release_tally;
    logic [TIME_WIDTH-1:0]  r_press_time;
    logic [TIME_WIDTH-1:0]  r_release_time;
    logic                   r_press_flip;
    logic                   r_release_flip;

    // captured sample and per-sample flags
    logic                  r_raw;
    logic [TIME_WIDTH-1:0] r_now;
    logic                  r_res_pressed;
    logic                  r_res_jp;
    logic                  r_res_jr;
    logic                  r_res_chg;
    logic                  r_res_dbl;
    logic                  r_res_hld;

    logic r_out_valid;

    logic                  accept;
    logic                  out_load;
    logic [TIME_WIDTH-1:0] now_in;
    t_unit_ctl             cmp_ctl;
    t_unit_ctl             mod_ctl;
    logic                  deb_gt;
    logic                  dc_gt;
    logic                  hold_gt;
    logic                  press_nth;
    logic                  release_nth;

    logic                   raw_chg;
    logic                   settled_new;
    logic                   stable_new;
    logic                   prev_new;
    logic                   pressed;
    logic                   chg;
    logic                   jp;
    logic                   jr;
    logic [COUNT_WIDTH-1:0] press_tally_new;
    logic [COUNT_WIDTH-1:0] release_tally_new;

    bde_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign accept  = i_item.valid && i_item.ready;
    assign now_in  = TIME_WIDTH'(i_item.now_ms);
    assign cmp_ctl = '{load: accept, step: (r_state == ST_CMP)};
    assign mod_ctl = '{load: (r_state == ST_SETTLE), step: (r_state == ST_MOD)};

    bde_diff_cmp #(.TIME_WIDTH(TIME_WIDTH)) u_deb_cmp (
        .i_clk (i_clk),
        .i_ctl (cmp_ctl),
        .i_a   (now_in),
        .i_b   (r_settle_start),
        .i_k   (cfg.debounce_delay),
        .o_gt  (deb_gt)
    );

    // a release edge makes the gap now - last release time
    bde_diff_cmp #(.TIME_WIDTH(TIME_WIDTH)) u_dc_cmp (
        .i_clk (i_clk),
        .i_ctl (cmp_ctl),
        .i_a   (now_in),
        .i_b   (r_release_time),
        .i_k   (cfg.dc_window),
        .o_gt  (dc_gt)
    );

    bde_diff_cmp #(.TIME_WIDTH(TIME_WIDTH)) u_hold_cmp (
        .i_clk (i_clk),
        .i_ctl (cmp_ctl),
        .i_a   (now_in),
        .i_b   (r_press_time),
        .i_k   (cfg.hold_delay),
        .o_gt  (hold_gt)
    );

    // remainder passes see the tallies including this sample's edge
    bde_mod_test #(.COUNT_WIDTH(COUNT_WIDTH)) u_press_mod (
        .i_clk     (i_clk),
        .i_ctl     (mod_ctl),
        .i_count   (press_tally_new),
        .i_modulus (cfg.count_modulus),
        .o_zero    (press_nth)
    );

    bde_mod_test #(.COUNT_WIDTH(COUNT_WIDTH)) u_release_mod (
        .i_clk     (i_clk),
        .i_ctl     (mod_ctl),
        .i_count   (release_tally_new),
        .i_modulus (cfg.count_modulus),
        .o_zero    (release_nth)
    );

    // settle decision and debounced edges, evaluated in ST_SETTLE
    assign raw_chg     = (r_raw != r_last_raw);
    assign settled_new = raw_chg ? 1'b0 : (deb_gt ? 1'b1 : r_settled);
    assign stable_new  = settled_new ? r_raw    : r_stable;
    assign prev_new    = settled_new ? r_stable : r_prev_stable;
    assign pressed     = (stable_new == cfg.active_level);
    assign chg         = (prev_new != stable_new);
    assign jp          = chg & pressed;
    assign jr          = chg & ~pressed;
    assign press_tally_new   = jp ? r_press_tally + 1'b1 : r_press_tally;
    assign release_tally_new = jr ? r_release_tally + 1'b1 : r_release_tally;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_CMP;
                    n_cnt   = SC_W'(TIME_WIDTH - 1);
                end
            end
            ST_CMP: begin
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_SETTLE;
                end
            end
            ST_SETTLE: begin
                n_state = ST_MOD;
                n_cnt   = SC_W'(COUNT_WIDTH - 1);
            end
            ST_MOD: begin
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign i_item.ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw      <= 1'b0;
            r_settled       <= 1'b1;
            r_prev_stable   <= 1'b0;
            r_stable        <= 1'b0;
            r_settle_start  <= '0;
            r_press_tally   <= '0;
            r_release_tally <= '0;
            r_press_time    <= '0;
            r_release_time  <= '0;
            r_press_flip    <= 1'b0;
            r_release_flip  <= 1'b1;
        end else if (accept) begin
            // clears act before this sample's edges
            if (i_item.clear_presses) begin
                r_press_tally <= '0;
            end
            if (i_item.clear_releases) begin
                r_release_tally <= '0;
            end
        end else if (r_state == ST_SETTLE) begin
            r_last_raw      <= r_raw;
            r_settled       <= settled_new;
            r_stable        <= stable_new;
            r_prev_stable   <= prev_new;
            r_press_tally   <= press_tally_new;
            r_release_tally <= release_tally_new;
            if (raw_chg) begin
                r_settle_start <= r_now;
            end
            if (jp) begin
                r_press_time <= r_now;
                r_press_flip <= ~r_press_flip;
            end
            if (jr) begin
                r_release_time <= r_now;
                r_release_flip <= ~r_release_flip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_raw <= i_item.pin_level;
            r_now <= now_in;
        end
        if (r_state == ST_SETTLE) begin
            r_res_pressed <= pressed;
            r_res_jp      <= jp;
            r_res_jr      <= jr;
            r_res_chg     <= chg;
            r_res_dbl     <= jr & ~dc_gt;
            // a press edge on this sample means zero time held
            r_res_hld     <= pressed & ~jp & hold_gt;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_result.is_pressed     <= r_res_pressed;
            o_result.just_pressed   <= r_res_jp;
            o_result.just_released  <= r_res_jr;
            o_result.changed        <= r_res_chg;
            o_result.press_count    <= CNT_OUT_W'(r_press_tally);
            o_result.release_count  <= CNT_OUT_W'(r_release_tally);
            o_result.press_toggle   <= r_press_flip;
            o_result.release_toggle <= r_release_flip;
            o_result.double_click   <= r_res_dbl;
            o_result.hold           <= r_res_hld;
            o_result.nth_press      <= press_nth;
            o_result.nth_release    <= release_nth;
        end
    end

    assign o_result.valid = r_out_valid;

    a_accept_starts_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_CMP))
        else $error("accepted sample did not start the compare pass");

    a_cmp_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP) |-> (r_cnt <= SC_W'(TIME_WIDTH - 1)))
        else $error("compare step counter out of range");

    a_result_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result presented without finishing a sample");

    a_tally_update_points: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_press_tally) |->
            (!$past(i_rst_n) || $past(accept) || ($past(r_state) == ST_SETTLE)))
        else $error("press tally changed outside a sample");

endmodule

`default_nettype wire

/* sim/button_debounce_event_detector_test.sv */
// Testbench for button_debounce_event_detector: drives raw button samples, predicts each
// event result in a model of its own and checks every field. Uses bde_pkg, bde_in_if and
// bde_out_if from src; registers are written and read back over the APB port.
module button_debounce_event_detector_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bde_pkg::*;

    typedef struct packed {
        logic                 pin_level;
        logic [TIME_IN_W-1:0] now_ms;
        logic                 clear_presses;
        logic                 clear_releases;
    } t_sample;

    typedef struct packed {
        logic                 is_pressed;
        logic                 just_pressed;
        logic                 just_released;
        logic                 changed;
        logic [CNT_OUT_W-1:0] press_count;
        logic [CNT_OUT_W-1:0] release_count;
        logic                 press_toggle;
        logic                 release_toggle;
        logic                 double_click;
        logic                 hold;
        logic                 nth_press;
        logic                 nth_release;
    } t_event;

    localparam int IDLE_PCT     = 17;
    localparam int RX_STALL_LEN = 300;
    localparam int TAIL_CYCLES  = 60;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bde_in_if  in_if ();
    bde_out_if out_if ();

    button_debounce_event_detector dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_if),
        .o_result (out_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 i_clk = ~i_clk;

    // debouncer model state and register copy
    t_cfg                 cfg = '{RST_ACTIVE_LEVEL, RST_DEBOUNCE, RST_DC_WINDOW,
                                  RST_HOLD_DELAY, RST_MODULUS};
    logic                 raw_prev       = 1'b0;
    logic                 accepted       = 1'b1;
    logic                 deb_prev       = 1'b0;
    logic                 deb_level      = 1'b0;
    logic [TIME_IN_W-1:0] settle_t0      = '0;
    logic [CNT_OUT_W-1:0] presses        = '0;
    logic [CNT_OUT_W-1:0] releases       = '0;
    logic [TIME_IN_W-1:0] press_t        = '0;
    logic [TIME_IN_W-1:0] release_t      = '0;
    logic [TIME_IN_W-1:0] last_release_t = '0;
    logic                 press_tog      = 1'b0;
    logic                 release_tog    = 1'b1;

    t_event               expected_events[$];
    int                   mismatches = 0;
    bit                   no_idle = 1'b0;
    bit                   rx_stall_req = 1'b0;
    int                   rx_stall_left = 0;
    logic [TIME_IN_W-1:0] clock_ms = '0;
    logic                 button_level = 1'b0;

    function automatic logic divisible_by(logic [CNT_OUT_W-1:0] count,
                                          logic [CFG_W-1:0] modulus);
        // modulus zero behaves as 2^16: only a zero count qualifies
        if (modulus == '0) begin
            return count == '0;
        end
        return (count % modulus) == '0;
    endfunction

    function automatic t_event predict_event(t_sample s);
        t_event               ev;
        logic [TIME_IN_W-1:0] span;
        logic                 pressed;
        logic                 chg;
        if (s.clear_presses) begin
            presses = '0;
        end
        if (s.clear_releases) begin
            releases = '0;
        end
        if (s.pin_level != raw_prev) begin
            accepted  = 1'b0;
            settle_t0 = s.now_ms;
        end else begin
            span = s.now_ms - settle_t0;
            if (span > cfg.debounce_delay) begin
                accepted = 1'b1;
            end
        end
        // debounced pair is frozen while the raw level is unsettled
        if (accepted) begin
            deb_prev  = deb_level;
            deb_level = s.pin_level;
        end
        pressed = (deb_level == cfg.active_level);
        chg     = (deb_prev != deb_level);
        ev.is_pressed    = pressed;
        ev.changed       = chg;
        ev.just_pressed  = chg & pressed;
        ev.just_released = chg & ~pressed;
        if (ev.just_pressed) begin
            presses   = presses + 1'b1;
            press_t   = s.now_ms;
            press_tog = ~press_tog;
        end else if (ev.just_released) begin
            releases       = releases + 1'b1;
            last_release_t = release_t;
            release_t      = s.now_ms;
            release_tog    = ~release_tog;
        end
        span = release_t - last_release_t;
        ev.double_click = ev.just_released && (span <= cfg.dc_window);
        span = s.now_ms - press_t;
        ev.hold = pressed && (span > cfg.hold_delay);
        raw_prev = s.pin_level;
        ev.press_count    = presses;
        ev.release_count  = releases;
        ev.press_toggle   = press_tog;
        ev.release_toggle = release_tog;
        ev.nth_press      = divisible_by(presses, cfg.count_modulus);
        ev.nth_release    = divisible_by(releases, cfg.count_modulus);
        return ev;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // receiver: random back-pressure, or a long hold-off when requested
    always @(negedge i_clk) begin
        if (rx_stall_req) begin
            rx_stall_left = RX_STALL_LEN;
            rx_stall_req  = 1'b0;
        end
        if (rx_stall_left > 0) begin
            rx_stall_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_event got;
        t_event want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = {out_if.is_pressed, out_if.just_pressed, out_if.just_released,
                   out_if.changed, out_if.press_count, out_if.release_count,
                   out_if.press_toggle, out_if.release_toggle, out_if.double_click,
                   out_if.hold, out_if.nth_press, out_if.nth_release};
            if (expected_events.size() == 0) begin
                $error("result transaction with no prediction pending");
                mismatches++;
            end else begin
                want = expected_events.pop_front();
                check_field("is_pressed", want.is_pressed, got.is_pressed);
                check_field("just_pressed", want.just_pressed, got.just_pressed);
                check_field("just_released", want.just_released, got.just_released);
                check_field("changed", want.changed, got.changed);
                check_field("press_count", want.press_count, got.press_count);
                check_field("release_count", want.release_count, got.release_count);
                check_field("press_toggle", want.press_toggle, got.press_toggle);
                check_field("release_toggle", want.release_toggle, got.release_toggle);
                check_field("double_click", want.double_click, got.double_click);
                check_field("hold", want.hold, got.hold);
                check_field("nth_press", want.nth_press, got.nth_press);
                check_field("nth_release", want.nth_release, got.nth_release);
            end
        end
    end

    // called and returns on a falling edge
    task automatic send_sample(t_sample s);
        if (!no_idle) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                in_if.valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        in_if.valid          <= 1'b1;
        in_if.pin_level      <= s.pin_level;
        in_if.now_ms         <= s.now_ms;
        in_if.clear_presses  <= s.clear_presses;
        in_if.clear_releases <= s.clear_releases;
        @(posedge i_clk);
        while (!in_if.ready) begin
            @(posedge i_clk);
        end
        expected_events.push_back(predict_event(s));
        @(negedge i_clk);
    endtask

    task automatic send_at(logic pin, logic [TIME_IN_W-1:0] now, logic clr_p, logic clr_r);
        send_sample('{pin, now, clr_p, clr_r});
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        @(negedge i_clk);
        while (expected_events.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    // write a register, then read it back
    task automatic set_reg(t_reg_idx idx, logic [APB_DATA_W-1:0] val);
        logic [APB_DATA_W-1:0] stored;
        stored = (idx == REG_ACTIVE_LEVEL) ? {31'b0, val[0]} : {16'b0, val[15:0]};
        for (int pass = 0; pass < 2; pass++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= (pass == 0);
            paddr   <= {idx, 2'b00};
            pwdata  <= val;
            @(negedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) begin
                @(posedge i_clk);
            end
            if (pass == 1) begin
                check_field("prdata", stored, prdata);
            end
            @(negedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        case (idx)
            REG_ACTIVE_LEVEL:   cfg.active_level   = val[0];
            REG_DEBOUNCE_DELAY: cfg.debounce_delay = val[15:0];
            REG_DC_WINDOW:      cfg.dc_window      = val[15:0];
            REG_HOLD_DELAY:     cfg.hold_delay     = val[15:0];
            REG_COUNT_MODULUS:  cfg.count_modulus  = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic lvl, int deb, int win, int hld, int modulus);
        wait_idle();
        set_reg(REG_ACTIVE_LEVEL, lvl);
        set_reg(REG_DEBOUNCE_DELAY, deb);
        set_reg(REG_DC_WINDOW, win);
        set_reg(REG_HOLD_DELAY, hld);
        set_reg(REG_COUNT_MODULUS, modulus);
    endtask

    // button sessions: a wanted level with contact bounce, time steps scaled to the
    // current delays; noise_pct of the samples jump to a random time and level
    task automatic run_sessions(int count, int noise_pct);
        t_sample     s;
        int unsigned dt;
        int unsigned k;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < noise_pct) begin
                s.now_ms    = $urandom;
                s.pin_level = $urandom_range(1);
            end else begin
                if ($urandom_range(99) < 20) begin
                    button_level = ~button_level;
                end
                s.pin_level = ($urandom_range(99) < 15) ? ~button_level : button_level;
                k = $urandom_range(9);
                if (k < 4) begin
                    dt = $urandom_range(3);
                end else if (k < 8) begin
                    dt = $urandom_range(int'(cfg.debounce_delay) + 2);
                end else if (k == 8) begin
                    dt = $urandom_range(int'(cfg.hold_delay) + 2);
                end else begin
                    dt = $urandom_range(int'(cfg.dc_window) + 2);
                end
                s.now_ms = clock_ms + dt;
            end
            clock_ms         = s.now_ms;
            s.clear_presses  = ($urandom_range(99) < 4);
            s.clear_releases = ($urandom_range(99) < 4);
            send_sample(s);
        end
    endtask

    // reset defaults: bounce, strict settle compare, frozen edge, hold, time wrap
    task automatic test_directed_defaults();
        send_at(1'b0, 32'd0, 1'b1, 1'b1);
        send_at(1'b1, 32'd10, 1'b0, 1'b0);
        send_at(1'b0, 32'd12, 1'b0, 1'b0);
        send_at(1'b1, 32'd15, 1'b0, 1'b0);
        send_at(1'b1, 32'd45, 1'b0, 1'b0);      // elapsed equals delay: not yet
        send_at(1'b1, 32'd46, 1'b0, 1'b0);      // accepted, release edge
        send_at(1'b0, 32'd47, 1'b0, 1'b0);      // unsettled: edge repeats
        send_at(1'b0, 32'd48, 1'b0, 1'b0);
        send_at(1'b0, 32'd78, 1'b0, 1'b0);      // press edge
        send_at(1'b0, 32'd1578, 1'b0, 1'b0);    // hold boundary
        send_at(1'b0, 32'd1579, 1'b0, 1'b0);
        send_at(1'b1, 32'd1600, 1'b0, 1'b0);
        send_at(1'b1, 32'd1631, 1'b0, 1'b0);
        send_at(1'b0, 32'd1700, 1'b0, 1'b0);
        send_at(1'b0, 32'd1731, 1'b1, 1'b0);    // clear with press edge
        send_at(1'b1, 32'd1800, 1'b0, 1'b0);
        send_at(1'b1, 32'd1831, 1'b1, 1'b1);    // clear with release edge, double click
        send_at(1'b1, 32'hFFFF_FFF0, 1'b0, 1'b0);
        send_at(1'b0, 32'hFFFF_FFF8, 1'b0, 1'b0);
        send_at(1'b0, 32'h0000_0010, 1'b0, 1'b0); // wrapped elapsed 24
        send_at(1'b0, 32'h0000_0017, 1'b0, 1'b1); // wrapped elapsed 31
        send_at(1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1);
    endtask

    task automatic test_random_defaults();
        run_sessions(200, 5);
    endtask

    // active high, every delay zero, modulus zero
    task automatic test_zero_settings();
        set_config(1'b1, 0, 0, 0, 0);
        run_sessions(120, 5);
    endtask

    task automatic test_max_settings();
        set_config(1'b0, 65535, 65535, 65535, 65535);
        run_sessions(120, 5);
    endtask

    // short delays, small modulus, both sides without idle cycles
    task automatic test_streaming();
        set_config(1'b1, 5, 50, 100, 3);
        no_idle = 1'b1;
        run_sessions(150, 3);
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        set_config(1'b0, 2, 20, 40, 2);
        rx_stall_req = 1'b1;
        run_sessions(40, 5);
        wait_idle();
        run_sessions(20, 5);
    endtask

    task automatic test_noise();
        set_config(1'b1, 3, 200, 500, 4);
        run_sessions(150, 60);
    endtask

    initial begin : main
        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        in_if.valid           = 1'b0;
        in_if.pin_level       = 1'b0;
        in_if.now_ms          = '0;
        in_if.clear_presses   = 1'b0;
        in_if.clear_releases  = 1'b0;
        out_if.ready          = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_defaults();
        test_random_defaults();
        test_zero_settings();
        test_max_settings();
        test_streaming();
        test_backpressure();
        test_noise();
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_events.size() != 0) begin
            $error("%0d predicted results never arrived", expected_events.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

/* button_debounce_event_detector.f */
src/bde_pkg.sv
src/bde_if.sv
src/bde_cfg_regs.sv
src/bde_diff_cmp.sv
src/bde_mod_test.sv
src/button_debounce_event_detector.sv
sim/button_debounce_event_detector_test.sv
